// ===== hw/rtl/sfat_pkg.sv =====
// shared types, constants and helper functions of the virtual fat16 sector generator
package sfat_pkg;

    localparam int ADDR_W      = 32;
    localparam int WIDX_W      = 6;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int SIZE_W      = 32;
    localparam int CLUS_W      = 16;
    localparam int ROW_W       = 5;
    localparam int ENT_W       = 4;
    localparam int IDX_W       = ROW_W + ENT_W;
    localparam int BCD_W       = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BASE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET    = 32'd12345;
    localparam logic [CLUS_W-1:0] CLUSTER_RESET = 16'd256;

    localparam logic [ADDR_W-1:0] PART_START    = 32'h0000_003f;
    localparam logic [ADDR_W-1:0] TABLE_SECTORS = 32'h0000_003e;
    localparam logic [ADDR_W-1:0] FAT_FIRST     = PART_START + 32'd1;
    localparam logic [ADDR_W-1:0] FAT_SECOND    = FAT_FIRST + TABLE_SECTORS;
    localparam logic [ADDR_W-1:0] FAT_LAST      = FAT_FIRST + 32'd2 * TABLE_SECTORS - 32'd1;
    localparam logic [ADDR_W-1:0] DIR_FIRST     = FAT_LAST + 32'd1;
    localparam logic [ADDR_W-1:0] DIR_LAST      = DIR_FIRST + 32'h200 / 32'd16 - 32'd1;

    localparam logic [WIDX_W-1:0] LAST_IDX = 6'd63;

    // fixed words, little-endian byte order
    localparam logic [WORD_W-1:0] MBR_W55   = 64'h01000000_00000000;
    localparam logic [WORD_W-1:0] MBR_W56   = 64'h003fffff_fe0b0001;
    localparam logic [WORD_W-1:0] MBR_W57   = 64'h00000000_f49e0000;
    localparam logic [WORD_W-1:0] SIG_W63   = 64'haa550000_00000000;
    localparam logic [WORD_W-1:0] BOOT_W1   = 64'h00010402_00000000;
    localparam logic [WORD_W-1:0] BOOT_W2   = 64'h003ef800_00020002;
    localparam logic [WORD_W-1:0] BOOT_W4   = 64'h00100020_0000f49e;
    localparam logic [WORD_W-1:0] BOOT_W5   = 64'h5350494c_4600003f;
    localparam logic [WORD_W-1:0] BOOT_W6   = 64'h41462020_20202059;
    localparam logic [WORD_W-1:0] BOOT_W7   = 64'h00002020_20363154;
    localparam logic [WORD_W-1:0] FAT_W0    = 64'hffffffff_fffffff8;
    localparam logic [WORD_W-1:0] FAT_W1    = 64'h00000000_ffffffff;
    localparam logic [WORD_W-1:0] LABEL_W0  = 64'h20205953_50494c46;
    localparam logic [WORD_W-1:0] LABEL_W1  = 64'h00000000_28202020;
    localparam logic [WORD_W-1:0] EXT_W1    = 64'h00000000_00545854;
    localparam logic [WORD_W-1:0] FILL_W1   = 64'h78787878_7878000a;
    localparam logic [WORD_W-1:0] FILL_ALL  = 64'h78787878_78787878;
    localparam logic [WORD_W-1:0] NAME_PAD  = 64'h20202020_20202046;

    typedef enum logic [2:0] {
        K_MBR,
        K_ZERO,
        K_BOOT,
        K_FAT_MARK,
        K_DIR,
        K_FILL
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] lba;
        logic [ROW_W-1:0]  row;
        logic [BCD_W-1:0]  bcd;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'h0, n};
        end else begin
            c = 8'h57 + {4'h0, n};
        end
        return c;
    endfunction

    // decimal digits of a directory index below 512, by reciprocal multiply
    function automatic logic [BCD_W-1:0] bcd_of(input logic [IDX_W-1:0] v);
        logic [14:0] ph;
        logic [3:0]  h;
        logic [6:0]  r;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [3:0]  u;
        ph = 15'(v) * 15'd41;
        h  = {1'b0, ph[14:12]};
        r  = 7'(v - 9'({5'd0, h} * 9'd100));
        pt = 15'(r) * 15'd205;
        t  = pt[14:11];
        u  = 4'(r - 7'({3'd0, t} * 7'd10));
        return {h, t, u};
    endfunction

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] b);
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] u;
        h = b[11:8];
        t = b[7:4];
        u = b[3:0];
        if (u == 4'd9) begin
            u = 4'd0;
            if (t == 4'd9) begin
                t = 4'd0;
                h = h + 4'd1;
            end else begin
                t = t + 4'd1;
            end
        end else begin
            u = u + 4'd1;
        end
        return {h, t, u};
    endfunction

endpackage

// ===== hw/rtl/sfat_front.sv =====
// front end: takes sector requests and classifies them into jobs
module sfat_front (
    input  logic                   i_in_valid,
    input  logic [31:0]            i_sector_address,
    input  logic                   i_full,
    output logic                   o_in_ready,
    output logic                   o_push,
    output sfat_pkg::t_job         o_job
);
    import sfat_pkg::*;

    logic [ROW_W-1:0] row;

    assign row        = 5'(i_sector_address - DIR_FIRST);
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_job.lba = i_sector_address;
        o_job.row = row;
        o_job.bcd = bcd_of({row, {ENT_W{1'b0}}});
        priority if (i_sector_address == '0) begin
            o_job.kind = K_MBR;
        end else if (i_sector_address < PART_START) begin
            o_job.kind = K_ZERO;
        end else if (i_sector_address == PART_START) begin
            o_job.kind = K_BOOT;
        end else if (i_sector_address <= FAT_LAST) begin
            if (i_sector_address == FAT_FIRST || i_sector_address == FAT_SECOND) begin
                o_job.kind = K_FAT_MARK;
            end else begin
                o_job.kind = K_ZERO;
            end
        end else if (i_sector_address <= DIR_LAST) begin
            o_job.kind = K_DIR;
        end else begin
            o_job.kind = K_FILL;
        end
    end

endmodule

// ===== hw/rtl/sfat_queue.sv =====
// short job queue between the front end and the word generator
module sfat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfat_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sfat_pkg::t_job  o_job
);
    import sfat_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count not raised on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count not lowered on pop");

endmodule

// ===== hw/rtl/sfat_back.sv =====
// back end: config registers, sector word generation and output register
module sfat_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_job_valid,
    input  sfat_pkg::t_job         i_job,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [5:0]             o_word_index,
    output logic [63:0]            o_data_word,
    output logic                   o_last_word
);
    import sfat_pkg::*;

    logic [SIZE_W-1:0] r_file_size;
    logic [CLUS_W-1:0] r_cluster;
    logic [WIDX_W-1:0] r_k;
    logic [BCD_W-1:0]  r_bcd;
    logic              r_valid;
    logic [WIDX_W-1:0] r_idx;
    logic [WORD_W-1:0] r_data;
    logic              r_last;

    logic              advance;
    logic [1:0]        q;
    logic [ENT_W-1:0]  ent;
    logic [IDX_W-1:0]  idx;
    logic [BCD_W-1:0]  cur_bcd;
    logic [CLUS_W-1:0] cluster;
    logic [WORD_W-1:0] name_w;
    logic [WORD_W-1:0] hex_w;
    logic [WORD_W-1:0] n_data;

    assign advance = i_job_valid && (!r_valid || i_out_ready);
    assign o_pop   = advance && (r_k == LAST_IDX);
    assign q       = r_k[1:0];
    assign ent     = r_k[WIDX_W-1:2];
    assign idx     = {i_job.row, ent};
    assign cur_bcd = (ent == '0) ? i_job.bcd : r_bcd;
    assign cluster = r_cluster + CLUS_W'(idx);

    always_comb begin
        name_w = NAME_PAD;
        if (cur_bcd[11:8] != 4'd0) begin
            name_w[15:8]  = {4'h3, cur_bcd[11:8]};
            name_w[23:16] = {4'h3, cur_bcd[7:4]};
            name_w[31:24] = {4'h3, cur_bcd[3:0]};
        end else if (cur_bcd[7:4] != 4'd0) begin
            name_w[15:8]  = {4'h3, cur_bcd[7:4]};
            name_w[23:16] = {4'h3, cur_bcd[3:0]};
        end else begin
            name_w[15:8]  = {4'h3, cur_bcd[3:0]};
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            hex_w[8*j +: 8] = hex_char(i_job.lba[28 - 4*j +: 4]);
        end
    end

    always_comb begin
        n_data = '0;
        unique case (i_job.kind)
            K_MBR: begin
                unique case (r_k)
                    6'd55:   n_data = MBR_W55;
                    6'd56:   n_data = MBR_W56;
                    6'd57:   n_data = MBR_W57;
                    6'd63:   n_data = SIG_W63;
                    default: n_data = '0;
                endcase
            end
            K_BOOT: begin
                unique case (r_k)
                    6'd1:    n_data = BOOT_W1;
                    6'd2:    n_data = BOOT_W2;
                    6'd4:    n_data = BOOT_W4;
                    6'd5:    n_data = BOOT_W5;
                    6'd6:    n_data = BOOT_W6;
                    6'd7:    n_data = BOOT_W7;
                    6'd63:   n_data = SIG_W63;
                    default: n_data = '0;
                endcase
            end
            K_FAT_MARK: begin
                unique case (r_k)
                    6'd0:    n_data = FAT_W0;
                    6'd1:    n_data = FAT_W1;
                    default: n_data = '0;
                endcase
            end
            K_DIR: begin
                if (idx == '0) begin
                    unique case (q)
                        2'd0:    n_data = LABEL_W0;
                        2'd1:    n_data = LABEL_W1;
                        default: n_data = '0;
                    endcase
                end else begin
                    unique case (q)
                        2'd0: n_data = name_w;
                        2'd1: n_data = EXT_W1;
                        2'd2: n_data = '0;
                        2'd3: n_data = {r_file_size[7:0], r_file_size[15:8],
                                        r_file_size[23:16], r_file_size[31:24],
                                        cluster, 16'h0000};
                    endcase
                end
            end
            K_FILL: begin
                unique case (r_k)
                    6'd0:    n_data = hex_w;
                    6'd1:    n_data = FILL_W1;
                    default: n_data = FILL_ALL;
                endcase
            end
            default: n_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= SIZE_RESET;
            r_cluster   <= CLUSTER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILE_SIZE:    r_file_size <= i_cfg_data;
                CFG_CLUSTER_BASE: r_cluster   <= i_cfg_data[CLUS_W-1:0];
                default:          r_file_size <= r_file_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_k     <= r_k + 1'b1;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_idx  <= r_k;
            r_data <= n_data;
            r_last <= (r_k == LAST_IDX);
            if (q == 2'd3) begin
                r_bcd <= bcd_inc(cur_bcd);
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_word_index = r_idx;
    assign o_data_word  = r_data;
    assign o_last_word  = r_last;

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_last == (r_idx == LAST_IDX)))
        else $error("last flag out of step with word index");

    a_next_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_ready && !r_last) |=>
            (!r_valid || (r_idx == $past(r_idx) + 1'b1)))
        else $error("word index skipped or repeated");

    a_new_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_ready && r_last) |=> (!r_valid || (r_idx == '0)))
        else $error("sector does not start at word zero");

endmodule

// ===== hw/rtl/synthetic_fat16_sector_generator_unit.sv =====
// top level of the virtual fat16 sector generator
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready    i_sector_address
//  word      out        o_out_valid / i_out_ready  o_word_index, o_data_word, o_last_word
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  each request yields 64 words, one per cycle while the output is not stalled
//  the output register gives one word per unstalled cycle; that single word port sets the rate
//  a two-entry job queue lets requests be taken while the previous sector streams out
//  reset is synchronous and needs no clearing pass; config regs return to defaults
//  a stalled output holds its word and the generator waits on it
module synthetic_fat16_sector_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_sector_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_word_index,
    output logic [63:0] o_data_word,
    output logic        o_last_word
);
    import sfat_pkg::*;

    logic full;
    logic push;
    logic pop;
    logic job_valid;
    t_job push_job;
    t_job head_job;

    sfat_front u_front (
        .i_in_valid       (i_in_valid),
        .i_sector_address (i_sector_address),
        .i_full           (full),
        .o_in_ready       (o_in_ready),
        .o_push           (push),
        .o_job            (push_job)
    );

    sfat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    sfat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_job_valid  (job_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word_index (o_word_index),
        .o_data_word  (o_data_word),
        .o_last_word  (o_last_word)
    );

endmodule

// ===== tb/tb_synthetic_fat16_sector_generator_unit.sv =====
// testbench of the virtual fat16 sector generator: requests against a byte-level sector model
module tb_synthetic_fat16_sector_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfat_pkg::*;

    localparam logic [47:0] VOL_LABEL = 48'h464c49505359;

    typedef struct {
        logic [31:0] lba;
        int unsigned gap;
        bit          drain;
    } t_sector_request;

    typedef struct packed {
        logic [5:0]  word_index;
        logic [63:0] data_word;
        logic        last_word;
    } t_sector_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_FILE_SIZE;
    logic [31:0] i_cfg_data = 32'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_sector_address = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_word_index;
    logic [63:0] o_data_word;
    logic        o_last_word;

    synthetic_fat16_sector_generator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sector_address (i_sector_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_data_word      (o_data_word),
        .o_last_word      (o_last_word)
    );

    always #4 i_clk = ~i_clk;

    logic [31:0]     file_size_setting = SIZE_RESET;
    logic [15:0]     cluster_base_setting = CLUSTER_RESET;
    logic [7:0]      sector_bytes [0:511];
    t_sector_request pending_requests[$];
    t_sector_request next_request;
    t_sector_word    expected_words[$];
    t_sector_word    oldest_word;
    int              requests_in_flight = 0;
    int              mismatch_count = 0;
    int              words_checked = 0;
    int              requests_sent = 0;
    int              register_settings = 1;
    int              kind_hits [0:5];
    bit              tx_calm = 1'b0;
    bit              rx_calm = 1'b0;
    bit              gap_loaded = 1'b0;
    int unsigned     gap_left = 0;
    int unsigned     stall_left = 0;

    function automatic logic [7:0] ascii_hex(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h57 + {4'h0, n};
    endfunction

    function automatic void put_be32(input int p, input logic [31:0] v);
        sector_bytes[p]     = v[31:24];
        sector_bytes[p + 1] = v[23:16];
        sector_bytes[p + 2] = v[15:8];
        sector_bytes[p + 3] = v[7:0];
    endfunction

    function automatic void put_label(input int p);
        int i;
        for (i = 0; i < 11; i++) begin
            sector_bytes[p + i] = (i < 6) ? VOL_LABEL[47 - 8 * i -: 8] : 8'h20;
        end
    endfunction

    function automatic t_kind sector_kind(input logic [31:0] lba);
        if (lba == 32'd0) begin
            return K_MBR;
        end else if (lba < PART_START) begin
            return K_ZERO;
        end else if (lba == PART_START) begin
            return K_BOOT;
        end else if (lba <= FAT_LAST) begin
            return (lba == FAT_FIRST || lba == FAT_SECOND) ? K_FAT_MARK : K_ZERO;
        end else if (lba <= DIR_LAST) begin
            return K_DIR;
        end
        return K_FILL;
    endfunction

    function automatic void fill_dir_entry(input int base, input int idx);
        int          i;
        logic [3:0]  d0;
        logic [3:0]  d1;
        logic [3:0]  d2;
        logic [15:0] clus;
        for (i = 0; i < 32; i++) begin
            sector_bytes[base + i] = 8'h00;
        end
        if (idx == 0) begin
            put_label(base);
            sector_bytes[base + 11] = 8'h28;
        end else begin
            d0 = 4'(idx % 10);
            d1 = 4'((idx / 10) % 10);
            d2 = 4'(idx / 100);
            for (i = 1; i < 8; i++) begin
                sector_bytes[base + i] = 8'h20;
            end
            sector_bytes[base] = "F";
            if (idx >= 100) begin
                sector_bytes[base + 1] = 8'h30 + {4'h0, d2};
                sector_bytes[base + 2] = 8'h30 + {4'h0, d1};
                sector_bytes[base + 3] = 8'h30 + {4'h0, d0};
            end else if (idx >= 10) begin
                sector_bytes[base + 1] = 8'h30 + {4'h0, d1};
                sector_bytes[base + 2] = 8'h30 + {4'h0, d0};
            end else begin
                sector_bytes[base + 1] = 8'h30 + {4'h0, d0};
            end
            sector_bytes[base + 8]  = "T";
            sector_bytes[base + 9]  = "X";
            sector_bytes[base + 10] = "T";
            clus = cluster_base_setting + 16'(idx);
            sector_bytes[base + 26] = clus[7:0];
            sector_bytes[base + 27] = clus[15:8];
            put_be32(base + 28, file_size_setting);
        end
    endfunction

    function automatic void predict_sector(input logic [31:0] lba);
        int           i;
        int           k;
        t_kind        kind;
        t_sector_word w;
        kind = sector_kind(lba);
        kind_hits[int'(kind)]++;
        for (i = 0; i < 512; i++) begin
            sector_bytes[i] = 8'h00;
        end
        case (kind)
            K_MBR: begin
                put_be32(444, 32'h00000001);
                put_be32(448, 32'h01000bfe);
                put_be32(452, 32'hffff3f00);
                put_be32(456, 32'h00009ef4);
                put_be32(508, 32'h000055aa);
            end
            K_BOOT: begin
                put_be32(12, 32'h02040100);
                put_be32(16, 32'h02000200);
                put_be32(20, 32'h00f83e00);
                put_be32(32, 32'h9ef40000);
                put_be32(36, 32'h20001000);
                put_be32(40, 32'h3f000000);
                put_be32(44, 32'h02000000);
                put_label(43);
                sector_bytes[54] = "F";
                sector_bytes[55] = "A";
                sector_bytes[56] = "T";
                sector_bytes[57] = "1";
                sector_bytes[58] = "6";
                for (i = 59; i < 62; i++) begin
                    sector_bytes[i] = 8'h20;
                end
                put_be32(508, 32'h000055aa);
            end
            K_FAT_MARK: begin
                put_be32(0, 32'hf8ffffff);
                put_be32(4, 32'hffffffff);
                put_be32(8, 32'hffffffff);
            end
            K_DIR: begin
                for (i = 0; i < 16; i++) begin
                    fill_dir_entry(32 * i, int'(lba - DIR_FIRST) * 16 + i);
                end
            end
            K_FILL: begin
                for (i = 0; i < 512; i++) begin
                    sector_bytes[i] = "x";
                end
                for (i = 0; i < 8; i++) begin
                    sector_bytes[i] = ascii_hex(lba[31 - 4 * i -: 4]);
                end
                sector_bytes[8] = 8'h0a;
                sector_bytes[9] = 8'h00;
            end
            default: begin
            end
        endcase
        for (k = 0; k < 64; k++) begin
            w.word_index = 6'(k);
            w.last_word  = (w.word_index == LAST_IDX);
            for (i = 0; i < 8; i++) begin
                w.data_word[8 * i +: 8] = sector_bytes[8 * k + i];
            end
            expected_words.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_loaded = 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                predict_sector(i_sector_address);
                requests_in_flight--;
                requests_sent++;
            end
            if (pending_requests.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    gap_left = pending_requests[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests[0].drain && expected_words.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    next_request = pending_requests.pop_front();
                    gap_loaded = 1'b0;
                    i_in_valid <= 1'b1;
                    i_sector_address <= next_request.lba;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word: index %0d data %h", o_word_index, o_data_word);
                    mismatch_count++;
                end else begin
                    oldest_word = expected_words.pop_front();
                    if (o_word_index !== oldest_word.word_index) begin
                        $error("word_index: expected %0d, got %0d",
                               oldest_word.word_index, o_word_index);
                        mismatch_count++;
                    end
                    if (o_data_word !== oldest_word.data_word) begin
                        $error("data_word: expected %h, got %h",
                               oldest_word.data_word, o_data_word);
                        mismatch_count++;
                    end
                    if (o_last_word !== oldest_word.last_word) begin
                        $error("last_word: expected %0d, got %0d",
                               oldest_word.last_word, o_last_word);
                        mismatch_count++;
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(16);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_sector(input logic [31:0] lba, input bit drain);
        t_sector_request r;
        r.lba = lba;
        r.gap = tx_calm ? 0 : $urandom_range(16);
        r.drain = drain;
        pending_requests.push_back(r);
        requests_in_flight++;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (requests_in_flight != 0 || expected_words.size() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == CFG_FILE_SIZE) begin
            file_size_setting = data;
        end else begin
            cluster_base_setting = data[15:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_lba();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return 32'd0;
        end else if (pick < 15) begin
            return $urandom_range(62, 1);
        end else if (pick < 20) begin
            return PART_START;
        end else if (pick < 28) begin
            return $urandom_range(1) ? FAT_FIRST : FAT_SECOND;
        end else if (pick < 35) begin
            return $urandom_range(FAT_LAST, FAT_FIRST);
        end else if (pick < 70) begin
            return $urandom_range(DIR_LAST, DIR_FIRST);
        end else if (pick < 85) begin
            return $urandom_range(4000, DIR_LAST + 1);
        end
        return $urandom();
    endfunction

    initial begin
        int i;
        int phase;
        for (i = 0; i < 6; i++) begin
            kind_hits[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, extremes of the address and every sector type
        queue_sector(32'd0, 1'b0);
        queue_sector(32'd1, 1'b0);
        queue_sector(32'd62, 1'b0);
        queue_sector(PART_START, 1'b0);
        queue_sector(FAT_FIRST, 1'b0);
        queue_sector(FAT_FIRST + 1, 1'b0);
        queue_sector(FAT_SECOND - 1, 1'b0);
        queue_sector(FAT_SECOND, 1'b1);
        queue_sector(FAT_LAST, 1'b0);
        queue_sector(DIR_FIRST, 1'b0);
        queue_sector(DIR_FIRST + 1, 1'b0);
        queue_sector(DIR_FIRST + 6, 1'b0);
        queue_sector(DIR_LAST, 1'b0);
        queue_sector(DIR_LAST + 1, 1'b0);
        queue_sector(32'hffffffff, 1'b0);
        queue_sector(32'h89abcdef, 1'b0);
        queue_sector(32'h76543210, 1'b0);
        wait_idle();

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        write_reg(CFG_FILE_SIZE, 32'hffffffff);
        write_reg(CFG_CLUSTER_BASE, 32'hffffffff);
        register_settings++;
        queue_sector(DIR_FIRST, 1'b0);
        queue_sector(DIR_LAST, 1'b0);
        queue_sector(DIR_FIRST + 7, 1'b0);
        wait_idle();

        write_reg(CFG_FILE_SIZE, 32'd0);
        write_reg(CFG_CLUSTER_BASE, 32'd0);
        register_settings++;
        queue_sector(DIR_FIRST, 1'b0);
        queue_sector(DIR_LAST, 1'b0);
        wait_idle();

        for (phase = 0; phase < 6; phase++) begin
            tx_calm = ($urandom_range(3) == 0);
            rx_calm = ($urandom_range(3) == 0);
            write_reg(CFG_FILE_SIZE, $urandom());
            write_reg(CFG_CLUSTER_BASE, $urandom());
            register_settings++;
            for (i = 0; i < 46; i++) begin
                queue_sector(random_lba(), $urandom_range(49) == 0);
            end
            wait_idle();
        end

        repeat (80) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            mismatch_count++;
        end
        $display("covered %0d requests: %0d mbr, %0d boot, %0d fat mark, %0d directory,",
                 requests_sent, kind_hits[int'(K_MBR)], kind_hits[int'(K_BOOT)],
                 kind_hits[int'(K_FAT_MARK)], kind_hits[int'(K_DIR)]);
        $display("  %0d fill, %0d zero; %0d words checked under %0d register settings",
                 kind_hits[int'(K_FILL)], kind_hits[int'(K_ZERO)], words_checked,
                 register_settings);
        if (mismatch_count == 0) begin
            $display("tb_synthetic_fat16_sector_generator_unit: clean");
        end else begin
            $display("tb_synthetic_fat16_sector_generator_unit: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("tb_synthetic_fat16_sector_generator_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sfat_pkg.sv
hw/rtl/sfat_front.sv
hw/rtl/sfat_queue.sv
hw/rtl/sfat_back.sv
hw/rtl/synthetic_fat16_sector_generator_unit.sv
tb/tb_synthetic_fat16_sector_generator_unit.sv
